>>> rtl/core/risc16_pkg.sv
// shared constants, codes, command/status structs and address helper for the risc16 core
// no dependencies; compile first
`default_nettype none

package risc16_pkg;

  // word memory geometry
  localparam int MEM_WORDS = 8192;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int RF_DEPTH  = 8;
  localparam int RF_AW     = $clog2(RF_DEPTH);

  // transaction kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_RDMEM = 2'd2;
  localparam logic [1:0] KIND_RDREG = 2'd3;

  // major opcodes, bits 15:13
  localparam logic [2:0] OP_RRR  = 3'd0;
  localparam logic [2:0] OP_ADDI = 3'd1;
  localparam logic [2:0] OP_J    = 3'd2;
  localparam logic [2:0] OP_JAL  = 3'd3;
  localparam logic [2:0] OP_LW   = 3'd4;
  localparam logic [2:0] OP_SW   = 3'd5;
  localparam logic [2:0] OP_JEQ  = 3'd6;
  localparam logic [2:0] OP_SLTI = 3'd7;

  // three-register function codes, bits 3:0
  localparam logic [3:0] FN_ADD = 4'b0000;
  localparam logic [3:0] FN_SUB = 4'b0001;
  localparam logic [3:0] FN_OR  = 4'b0010;
  localparam logic [3:0] FN_AND = 4'b0011;
  localparam logic [3:0] FN_SLT = 4'b0100;
  localparam logic [3:0] FN_JR  = 4'b1000;

  localparam logic [2:0] REG_LINK = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic latch_in;
    logic start;
    logic mem_wr_item;
    logic mem_wr_sw;
    logic mem_rd_item;
    logic mem_rd_fetch;
    logic mem_rd_ea;
    logic rf_rd_item;
    logic rf_rd_ra;
    logic rf_rd_rb;
    logic cap_read_mem;
    logic cap_read_rf;
    logic cap_ir;
    logic cap_a;
    logic cap_b;
    logic exec_commit;
    logic load_commit;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       halted;
    logic       op_lw;
    logic       op_sw;
    logic       clr_last;
    logic       out_free;
  } dp_sts_t;

  // 13-bit address reduced modulo the memory size; quotient is below eight
  function automatic logic [MEM_AW-1:0] mem_index(input logic [12:0] addr);
    logic [16:0] rem;
    logic [16:0] step;
    rem = {4'b0000, addr};
    for (int i = 2; i >= 0; i--) begin
      step = 17'(MEM_WORDS) << i;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[MEM_AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/risc16_if.sv
// channel interfaces of the risc16 core: item input and result output
// depends on nothing; compiled after risc16_pkg
`default_nettype none

interface risc16_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] address;
  logic [15:0] data;

  modport source (output valid, output kind, output address, output data, input ready);
  modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

interface risc16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        is_halted;
  logic [15:0] read_value;
  logic        reg_write_valid;
  logic [2:0]  reg_write_index;
  logic [15:0] reg_write_value;

  modport source (output valid, output next_pc, output is_halted, output read_value,
                  output reg_write_valid, output reg_write_index, output reg_write_value,
                  input ready);
  modport sink   (input valid, input next_pc, input is_halted, input read_value,
                  input reg_write_valid, input reg_write_index, input reg_write_value,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/risc16_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependency
`default_nettype none

module risc16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/risc16_ctrl.sv
// sequencing state machine of the risc16 core
// depends on risc16_pkg (command and status structs, transaction kinds)
`default_nettype none

module risc16_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire risc16_pkg::dp_sts_t sts,
  output risc16_pkg::dp_cmd_t      cmd
);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_DISP  = 11'b000_0000_0100,
    ST_MRD   = 11'b000_0000_1000,
    ST_RRD   = 11'b000_0001_0000,
    ST_FETCH = 11'b000_0010_0000,
    ST_RDA   = 11'b000_0100_0000,
    ST_RDB   = 11'b000_1000_0000,
    ST_EXEC  = 11'b001_0000_0000,
    ST_LOAD  = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd.start = 1'b1;
        case (sts.kind)
          risc16_pkg::KIND_LOAD: begin
            cmd.mem_wr_item = 1'b1;
            state_nxt       = ST_DONE;
          end
          risc16_pkg::KIND_RUN: begin
            if (sts.halted) begin
              state_nxt = ST_DONE;
            end else begin
              cmd.mem_rd_fetch = 1'b1;
              state_nxt        = ST_FETCH;
            end
          end
          risc16_pkg::KIND_RDMEM: begin
            cmd.mem_rd_item = 1'b1;
            state_nxt       = ST_MRD;
          end
          default: begin
            cmd.rf_rd_item = 1'b1;
            state_nxt      = ST_RRD;
          end
        endcase
      end
      ST_MRD: begin
        cmd.cap_read_mem = 1'b1;
        state_nxt        = ST_DONE;
      end
      ST_RRD: begin
        cmd.cap_read_rf = 1'b1;
        state_nxt       = ST_DONE;
      end
      ST_FETCH: begin
        cmd.cap_ir   = 1'b1;
        cmd.rf_rd_ra = 1'b1;
        state_nxt    = ST_RDA;
      end
      ST_RDA: begin
        cmd.cap_a    = 1'b1;
        cmd.rf_rd_rb = 1'b1;
        state_nxt    = ST_RDB;
      end
      ST_RDB: begin
        cmd.cap_b = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec_commit = 1'b1;
        if (sts.op_lw) begin
          cmd.mem_rd_ea = 1'b1;
          state_nxt     = ST_LOAD;
        end else begin
          cmd.mem_wr_sw = sts.op_sw;
          state_nxt     = ST_DONE;
        end
      end
      ST_LOAD: begin
        cmd.load_commit = 1'b1;
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // no transaction is taken until the clearing pass has run to its last word
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !sts.clr_last) |=> !in_ready)
    else $error("input taken before memory clear finished");

  // an accepted transaction is dispatched on the very next cycle
  a_done_after_disp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_in |=> cmd.start)
    else $error("accepted transaction not dispatched");

endmodule

`default_nettype wire

>>> rtl/core/risc16_dp.sv
// datapath of the risc16 core: architectural state, word memory, register file, alu,
// output register; depends on risc16_pkg and risc16_ram
`default_nettype none

module risc16_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire risc16_pkg::dp_cmd_t cmd,
  output risc16_pkg::dp_sts_t      sts,
  input  wire logic [1:0]          in_kind,
  input  wire logic [12:0]         in_address,
  input  wire logic [15:0]         in_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [15:0]              out_next_pc,
  output logic                     out_is_halted,
  output logic [15:0]              out_read_value,
  output logic                     out_reg_write_valid,
  output logic [2:0]               out_reg_write_index,
  output logic [15:0]              out_reg_write_value
);

  localparam int AW  = risc16_pkg::MEM_AW;
  localparam int RAW = risc16_pkg::RF_AW;
  localparam int RF_DEPTH_M = risc16_pkg::RF_DEPTH - 1;

  // latched transaction
  logic [1:0]  kind_r;
  logic [12:0] addr_r;
  logic [15:0] data_r;

  // architectural state
  logic [15:0]         pc_r;
  logic                halted_r;
  logic [RF_DEPTH_M:0] rf_vld_r;

  // instruction and operands
  logic [15:0] ir_r, a_r, b_r;

  // result staging and output register
  logic [15:0] res_read_r, res_wval_r;
  logic        res_wv_r;
  logic [2:0]  res_wi_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pc_r, out_read_r, out_wval_r;
  logic        out_halt_r, out_wv_r;
  logic [2:0]  out_wi_r;

  logic [AW-1:0] clr_cnt_r;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  logic           rf_we;
  logic [RAW-1:0] rf_waddr, rf_raddr;
  logic [15:0]    rf_wdata, rf_rdata, rf_val;
  logic           rf_rvld_r;

  // alu
  logic [15:0] imm, pc1, target, ea_sum, alu_val, exec_pc;
  logic [12:0] ea;
  logic [2:0]  alu_idx;
  logic        alu_we, halt_set;
  logic        out_free;

  always_comb begin
    imm      = {{9{ir_r[6]}}, ir_r[6:0]};
    pc1      = pc_r + 16'd1;
    target   = {3'b000, ir_r[12:0]};
    ea_sum   = a_r + imm;
    ea       = ea_sum[12:0];
    alu_we   = 1'b0;
    alu_idx  = ir_r[9:7];
    alu_val  = '0;
    exec_pc  = pc1;
    halt_set = 1'b0;
    case (ir_r[15:13])
      risc16_pkg::OP_RRR: begin
        alu_idx = ir_r[6:4];
        case (ir_r[3:0])
          risc16_pkg::FN_ADD: begin
            alu_we  = 1'b1;
            alu_val = a_r + b_r;
          end
          risc16_pkg::FN_SUB: begin
            alu_we  = 1'b1;
            alu_val = a_r - b_r;
          end
          risc16_pkg::FN_OR: begin
            alu_we  = 1'b1;
            alu_val = a_r | b_r;
          end
          risc16_pkg::FN_AND: begin
            alu_we  = 1'b1;
            alu_val = a_r & b_r;
          end
          risc16_pkg::FN_SLT: begin
            alu_we  = 1'b1;
            alu_val = {15'd0, (a_r < b_r)};
          end
          risc16_pkg::FN_JR: begin
            exec_pc = a_r;
          end
          default: begin
          end
        endcase
      end
      risc16_pkg::OP_ADDI: begin
        alu_we  = 1'b1;
        alu_val = ea_sum;
      end
      risc16_pkg::OP_J: begin
        if (target == pc_r) begin
          halt_set = 1'b1;
          exec_pc  = pc_r;
        end else begin
          exec_pc = target;
        end
      end
      risc16_pkg::OP_JAL: begin
        alu_we  = 1'b1;
        alu_idx = risc16_pkg::REG_LINK;
        alu_val = pc1;
        exec_pc = target;
      end
      risc16_pkg::OP_JEQ: begin
        exec_pc = (a_r == b_r) ? (pc1 + imm) : pc1;
      end
      risc16_pkg::OP_SLTI: begin
        alu_we  = 1'b1;
        alu_val = {15'd0, (a_r < imm)};
      end
      default: begin
      end
    endcase
  end

  // word memory ports
  always_comb begin
    mem_we = cmd.clear_wr | cmd.mem_wr_item | cmd.mem_wr_sw;
    if (cmd.clear_wr) begin
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.mem_wr_item) begin
      mem_waddr = risc16_pkg::mem_index(addr_r);
      mem_wdata = data_r;
    end else begin
      mem_waddr = risc16_pkg::mem_index(ea);
      mem_wdata = b_r;
    end
    if (cmd.mem_rd_fetch) begin
      mem_raddr = risc16_pkg::mem_index(pc_r[12:0]);
    end else if (cmd.mem_rd_ea) begin
      mem_raddr = risc16_pkg::mem_index(ea);
    end else if (cmd.mem_rd_item) begin
      mem_raddr = risc16_pkg::mem_index(addr_r);
    end else begin
      mem_raddr = '0;
    end
  end

  // register file ports; register zero is never written so it always reads zero
  always_comb begin
    if (cmd.rf_rd_ra) begin
      rf_raddr = mem_rdata[12:10];
    end else if (cmd.rf_rd_rb) begin
      rf_raddr = ir_r[9:7];
    end else if (cmd.rf_rd_item) begin
      rf_raddr = addr_r[RAW-1:0];
    end else begin
      rf_raddr = '0;
    end
    rf_we    = (cmd.exec_commit && alu_we && alu_idx != 3'd0) ||
               (cmd.load_commit && ir_r[9:7] != 3'd0);
    rf_waddr = cmd.load_commit ? ir_r[9:7] : alu_idx;
    rf_wdata = cmd.load_commit ? mem_rdata : alu_val;
    rf_val   = rf_rvld_r ? rf_rdata : 16'd0;
  end

  risc16_ram #(
    .WIDTH (16),
    .DEPTH (risc16_pkg::MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  risc16_ram #(
    .WIDTH (16),
    .DEPTH (risc16_pkg::RF_DEPTH)
  ) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      halted_r    <= 1'b0;
      rf_vld_r    <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.clear_wr) begin
        clr_cnt_r <= AW'(clr_cnt_r + 1'b1);
      end
      if (cmd.exec_commit) begin
        pc_r     <= exec_pc;
        halted_r <= halted_r | halt_set;
      end
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rf_rvld_r <= rf_vld_r[rf_raddr];
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      addr_r <= in_address;
      data_r <= in_data;
    end
    if (cmd.cap_ir) begin
      ir_r <= mem_rdata;
    end
    if (cmd.cap_a) begin
      a_r <= rf_val;
    end
    if (cmd.cap_b) begin
      b_r <= rf_val;
    end
    if (cmd.start) begin
      res_read_r <= '0;
      res_wv_r   <= 1'b0;
      res_wi_r   <= '0;
      res_wval_r <= '0;
    end else begin
      if (cmd.cap_read_mem) begin
        res_read_r <= mem_rdata;
      end
      if (cmd.cap_read_rf) begin
        res_read_r <= rf_val;
      end
      if (rf_we) begin
        res_wv_r   <= 1'b1;
        res_wi_r   <= rf_waddr;
        res_wval_r <= rf_wdata;
      end
    end
    if (cmd.out_load) begin
      out_pc_r   <= pc_r;
      out_halt_r <= halted_r;
      out_read_r <= res_read_r;
      out_wv_r   <= res_wv_r;
      out_wi_r   <= res_wi_r;
      out_wval_r <= res_wval_r;
    end
  end

  always_comb begin
    sts.kind     = kind_r;
    sts.halted   = halted_r;
    sts.op_lw    = (ir_r[15:13] == risc16_pkg::OP_LW);
    sts.op_sw    = (ir_r[15:13] == risc16_pkg::OP_SW);
    sts.clr_last = (clr_cnt_r == AW'(risc16_pkg::MEM_WORDS - 1));
    sts.out_free = out_free;
  end

  assign out_valid           = out_valid_r;
  assign out_next_pc         = out_pc_r;
  assign out_is_halted       = out_halt_r;
  assign out_read_value      = out_read_r;
  assign out_reg_write_valid = out_wv_r;
  assign out_reg_write_index = out_wi_r;
  assign out_reg_write_value = out_wval_r;

  // register zero stays unwritten
  a_r0_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0])
    else $error("register zero marked written");

  // once halted, only reset leaves the halt
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  // a result never overwrites one that has not been taken
  a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register overrun");

  // a reported write always names a nonzero register
  a_wr_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wv_r) |-> (out_wi_r != 3'd0))
    else $error("write reported to register zero");

endmodule

`default_nettype wire

>>> rtl/core/sixteen_bit_risc_core_step.sv
// top level of the sixteen-bit risc core: controller plus datapath behind two channels
// depends on risc16_pkg, risc16_if, risc16_ram, risc16_ctrl, risc16_dp
`default_nettype none

// channel  dir  handshake            payload
// in_if    in   in_if.valid/ready    kind[1:0], address[12:0], data[15:0]
// out_if   out  out_if.valid/ready   next_pc, is_halted, read_value, reg_write_valid,
//                                    reg_write_index, reg_write_value
//
// each transaction is stepped through its states one at a time: a memory load, or an execute
// while halted, goes from dispatch to done; a memory or register read adds a capture state; an
// executed instruction uses the single registered read port of the word memory and of the
// register file one after another (fetch, operand a, operand b, data word for lw)
// reset: synchronous, active low; afterwards a clearing pass writes zero to every memory
// word, one a cycle, all MEM_WORDS (8192) of them, with in_if.ready held low throughout
// stalls: one output register; a new transaction is taken while a result waits, and the
// core holds its finished result until the output register frees up

module sixteen_bit_risc_core_step (
  input wire logic      clk,
  input wire logic      rst_n,
  risc16_in_if.sink     in_if,
  risc16_out_if.source  out_if
);

  // command and status between the sequencer and the datapath
  risc16_pkg::dp_cmd_t cmd;
  risc16_pkg::dp_sts_t sts;

  // sequencer: owns the input handshake, steps each transaction through its states
  risc16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: pc, halt flag, register file, word memory, alu and the output register
  risc16_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_if.kind),
    .in_address          (in_if.address),
    .in_data             (in_if.data),
    .out_ready           (out_if.ready),
    .out_valid           (out_if.valid),
    .out_next_pc         (out_if.next_pc),
    .out_is_halted       (out_if.is_halted),
    .out_read_value      (out_if.read_value),
    .out_reg_write_valid (out_if.reg_write_valid),
    .out_reg_write_index (out_if.reg_write_index),
    .out_reg_write_value (out_if.reg_write_value)
  );

endmodule

`default_nettype wire
